[sv/nsc_pkg.sv]
package nsc_pkg;

    // Sentence framing characters.
    localparam logic [7:0] ASC_DOLLAR = 8'h24;
    localparam logic [7:0] ASC_COMMA  = 8'h2C;
    localparam logic [7:0] ASC_STAR   = 8'h2A;
    localparam logic [7:0] ASC_CR     = 8'h0D;
    localparam logic [7:0] ASC_LF     = 8'h0A;
    localparam logic [7:0] ASC_PLUS   = 8'h2B;
    localparam logic [7:0] ASC_MINUS  = 8'h2D;
    localparam logic [7:0] ASC_SPACE  = 8'h20;

    // Header letters after the dollar, and the number of them.
    localparam logic [2:0] HDR_LEN = 3'd5;

    // Comma positions of the integer fields that are kept.
    localparam logic [3:0] FIELD_COUNT   = 4'd14;
    localparam logic [3:0] FIELD_WEEK    = 4'd1;
    localparam logic [3:0] FIELD_SATS_A  = 4'd13;

    // Magnitude cap of a decimal field.
    localparam logic [16:0] MAG_CAP = 17'd65536;

    // Status codes that map to a navigation state.
    localparam logic [7:0] ST_SINGLE_A = 8'h03;
    localparam logic [7:0] ST_SINGLE_B = 8'h04;
    localparam logic [7:0] ST_FIXED_A  = 8'h45;
    localparam logic [7:0] ST_FIXED_B  = 8'h4B;
    localparam logic [7:0] ST_FLOAT_A  = 8'h55;
    localparam logic [7:0] ST_FLOAT_B  = 8'h5B;

    localparam logic [1:0] NAV_SINGLE  = 2'd0;
    localparam logic [1:0] NAV_FLOAT   = 2'd1;
    localparam logic [1:0] NAV_FIXED   = 2'd2;
    localparam logic [1:0] NAV_INVALID = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_HEADER  = 4'd1,
        PH_FIELDS  = 4'd2,
        PH_STAT_HI = 4'd3,
        PH_STAT_LO = 4'd4,
        PH_STAR    = 4'd5,
        PH_SUM_HI  = 4'd6,
        PH_SUM_LO  = 4'd7,
        PH_CR      = 4'd8,
        PH_CLOSE   = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        FS_EMPTY   = 2'd0,
        FS_SPACE   = 2'd1,
        FS_NUMBER  = 2'd2,
        FS_STOPPED = 2'd3
    } field_stage_t;

    // Commands from the sentence sequencer to the field decoder.
    typedef struct packed {
        logic feed;
        logic clear;
    } field_ctl_t;

    // Saturated values of the field currently being decoded.
    typedef struct packed {
        logic              nonempty;
        logic signed [15:0] week;
        logic signed [7:0]  sats;
    } field_res_t;

    typedef struct packed {
        logic               lf_ok;
        logic [7:0]         status_byte;
        logic [1:0]         nav_state;
        logic signed [15:0] gps_week;
        logic signed [7:0]  sats_first;
        logic signed [7:0]  sats_second;
    } result_t;

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h47; // G
            3'd1:    ch = 8'h50; // P
            3'd2:    ch = 8'h46; // F
            3'd3:    ch = 8'h50; // P
            3'd4:    ch = 8'h44; // D
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Upper-case hex digit: bit 4 flags a valid digit, bits 3:0 its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] r;
        logic [7:0] d;
        r = 5'd0;
        d = 8'd0;
        if (ch inside {[8'h30:8'h39]}) begin
            d = ch - 8'h30;
            r = {1'b1, d[3:0]};
        end
        else if (ch inside {[8'h41:8'h46]}) begin
            d = ch - 8'h37;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

    function automatic logic [1:0] nav_map(input logic [7:0] st);
        logic [1:0] n;
        if (st == ST_SINGLE_A || st == ST_SINGLE_B) begin
            n = NAV_SINGLE;
        end
        else if (st == ST_FIXED_A || st == ST_FIXED_B) begin
            n = NAV_FIXED;
        end
        else if (st == ST_FLOAT_A || st == ST_FLOAT_B) begin
            n = NAV_FLOAT;
        end
        else begin
            n = NAV_INVALID;
        end
        return n;
    endfunction

endpackage

[sv/nav_sentence_checksum_parser.sv]
// The closing byte is held in the input register, and its result word in the output register.
// Throughput: one byte word per cycle while the output register is free to take a result.
// The input register and the output register let a byte be taken while a result waits.
// Reset: rst_n is asynchronous and active low; it returns the parser to waiting for
// a dollar sign, clears the checksum, status and held values, and empties both registers.

module nav_sentence_checksum_parser
    import nsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // [7:0] status_byte, [9:8] nav_state,
                                       // [25:10] gps_week, [33:26] sats_first,
                                       // [41:34] sats_second, [47:42] zero
    output logic        m_axis_tuser   // [0] lf_ok
);

    // Input register: holds one received byte until the sequencer takes it.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;

    // Output register: holds one finished result until the sink takes it.
    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg, out_data_next;

    logic       out_free;
    logic       step;
    logic       res_valid;
    result_t    res;
    field_ctl_t fctl;
    field_res_t fres;

    // The sequencer advances whenever the output register can take what it makes.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_axis_tready) begin
            in_valid_next = s_axis_tvalid;
            in_byte_next  = s_axis_tdata;
        end
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_free) begin
            out_valid_next = step && res_valid;
            out_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg  <= in_byte_next;
        out_data_reg <= out_data_next;
    end

    // Integer field decoder for the comma-separated fields.
    nsc_field u_field (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (fctl),
        .rx_byte (in_byte_reg),
        .res     (fres)
    );

    // Sentence sequencer: header, commas, status, checksum and line end.
    nsc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .fres      (fres),
        .fctl      (fctl),
        .res_valid (res_valid),
        .res       (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.lf_ok;
    assign m_axis_tdata  = {6'd0,
                            out_data_reg.sats_second,
                            out_data_reg.sats_first,
                            out_data_reg.gps_week,
                            out_data_reg.nav_state,
                            out_data_reg.status_byte};

endmodule

[sv/nsc_field.sv]
module nsc_field
    import nsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  field_ctl_t ctl,
    input  logic [7:0] rx_byte,
    output field_res_t res
);

    logic [16:0]  accum_reg, accum_next;
    field_stage_t stage_reg, stage_next;
    logic         neg_reg, neg_next;

    logic         is_space;
    logic         is_digit;
    logic [7:0]   digit_full;
    logic [19:0]  prod;

    assign is_space   = (rx_byte == ASC_SPACE) || (rx_byte inside {[8'h09:8'h0D]});
    assign is_digit   = rx_byte inside {[8'h30:8'h39]};
    assign digit_full = rx_byte - 8'h30;
    // Times ten as two shifts, plus the new digit.
    assign prod = {accum_reg, 3'b000} + {2'b00, accum_reg, 1'b0} + {16'd0, digit_full[3:0]};

    always_comb
    begin
        accum_next = accum_reg;
        stage_next = stage_reg;
        neg_next   = neg_reg;
        if (ctl.clear) begin
            accum_next = '0;
            stage_next = FS_EMPTY;
            neg_next   = 1'b0;
        end
        else if (ctl.feed) begin
            case (stage_reg)
                FS_EMPTY, FS_SPACE:
                begin
                    if (is_space) begin
                        stage_next = FS_SPACE;
                    end
                    else if (rx_byte == ASC_PLUS || rx_byte == ASC_MINUS) begin
                        neg_next   = (rx_byte == ASC_MINUS);
                        stage_next = FS_NUMBER;
                    end
                    else if (is_digit) begin
                        accum_next = {13'd0, digit_full[3:0]};
                        stage_next = FS_NUMBER;
                    end
                    else begin
                        stage_next = FS_STOPPED;
                    end
                end
                FS_NUMBER:
                begin
                    if (is_digit) begin
                        accum_next = (prod > {3'b000, MAG_CAP}) ? MAG_CAP : prod[16:0];
                    end
                    else begin
                        stage_next = FS_STOPPED;
                    end
                end
                default:
                begin
                    stage_next = stage_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            accum_reg <= '0;
            stage_reg <= FS_EMPTY;
            neg_reg   <= 1'b0;
        end
        else begin
            accum_reg <= accum_next;
            stage_reg <= stage_next;
            neg_reg   <= neg_next;
        end
    end

    // Signed value clamped to the range of each output field.
    always_comb
    begin
        res.nonempty = (stage_reg != FS_EMPTY);
        if (neg_reg) begin
            res.week = (accum_reg > 17'd32768) ? 16'sh8000 : -$signed(accum_reg[15:0]);
            res.sats = (accum_reg > 17'd128)   ? 8'sh80    : -$signed(accum_reg[7:0]);
        end
        else begin
            res.week = (accum_reg > 17'd32767) ? 16'sh7FFF : $signed(accum_reg[15:0]);
            res.sats = (accum_reg > 17'd127)   ? 8'sh7F    : $signed(accum_reg[7:0]);
        end
    end

endmodule

[sv/nsc_parser.sv]
module nsc_parser
    import nsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  field_res_t fres,
    output field_ctl_t fctl,
    output logic       res_valid,
    output result_t    res
);

    phase_t             phase_reg, phase_next;
    logic [2:0]         hpos_reg, hpos_next;
    logic               hmatch_reg, hmatch_next;
    logic [3:0]         comma_reg, comma_next;
    logic [7:0]         xor_reg, xor_next;
    logic [3:0]         hi_nib_reg, hi_nib_next;
    logic [7:0]         status_reg, status_next;
    logic signed [15:0] week_pend_reg, week_pend_next;
    logic               week_pv_reg, week_pv_next;
    logic signed [15:0] week_hold_reg, week_hold_next;
    logic signed [7:0]  sa_pend_reg, sa_pend_next;
    logic               sa_pv_reg, sa_pv_next;
    logic signed [7:0]  sa_hold_reg, sa_hold_next;
    logic signed [7:0]  sb_hold_reg, sb_hold_next;

    logic [4:0]         hx;
    logic [3:0]         comma_inc;

    assign hx        = hex_decode(rx_byte);
    assign comma_inc = comma_reg + 4'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        hpos_next      = hpos_reg;
        hmatch_next    = hmatch_reg;
        comma_next     = comma_reg;
        xor_next       = xor_reg;
        hi_nib_next    = hi_nib_reg;
        status_next    = status_reg;
        week_pend_next = week_pend_reg;
        week_pv_next   = week_pv_reg;
        week_hold_next = week_hold_reg;
        sa_pend_next   = sa_pend_reg;
        sa_pv_next     = sa_pv_reg;
        sa_hold_next   = sa_hold_reg;
        sb_hold_next   = sb_hold_reg;
        fctl           = '0;
        res_valid      = 1'b0;

        res.lf_ok       = (rx_byte == ASC_LF);
        res.status_byte = status_reg;
        res.nav_state   = nav_map(status_reg);
        res.gps_week    = week_hold_reg;
        res.sats_first  = sa_hold_reg;
        res.sats_second = sb_hold_reg;

        if (step) begin
            if (rx_byte == ASC_DOLLAR) begin
                // A dollar restarts the sentence whatever came before.
                phase_next   = PH_HEADER;
                hpos_next    = 3'd0;
                hmatch_next  = 1'b1;
                comma_next   = 4'd0;
                xor_next     = 8'd0;
                week_pv_next = 1'b0;
                sa_pv_next   = 1'b0;
                fctl.clear   = 1'b1;
            end
            else begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_HEADER:
                    begin
                        xor_next = xor_reg ^ rx_byte;
                        if (rx_byte == ASC_COMMA) begin
                            if (hmatch_reg && hpos_reg == HDR_LEN) begin
                                comma_next = 4'd0;
                                fctl.clear = 1'b1;
                                phase_next = PH_FIELDS;
                            end
                            else begin
                                phase_next = PH_IDLE;
                            end
                        end
                        else if (hpos_reg < HDR_LEN) begin
                            if (rx_byte != hdr_char(hpos_reg)) begin
                                hmatch_next = 1'b0;
                            end
                            hpos_next = hpos_reg + 3'd1;
                        end
                        else begin
                            // Header too long; park one past the letters.
                            hmatch_next = 1'b0;
                            if (hpos_reg == HDR_LEN) begin
                                hpos_next = hpos_reg + 3'd1;
                            end
                        end
                    end
                    PH_FIELDS:
                    begin
                        xor_next = xor_reg ^ rx_byte;
                        if (rx_byte != ASC_COMMA) begin
                            fctl.feed = 1'b1;
                        end
                        else begin
                            comma_next = comma_inc;
                            fctl.clear = 1'b1;
                            if (comma_inc == FIELD_WEEK && fres.nonempty) begin
                                week_pend_next = fres.week;
                                week_pv_next   = 1'b1;
                            end
                            else if (comma_inc == FIELD_SATS_A && fres.nonempty) begin
                                sa_pend_next = fres.sats;
                                sa_pv_next   = 1'b1;
                            end
                            else if (comma_inc == FIELD_COUNT) begin
                                // Values are committed only at the last comma.
                                if (week_pv_reg) begin
                                    week_hold_next = week_pend_reg;
                                end
                                if (sa_pv_reg) begin
                                    sa_hold_next = sa_pend_reg;
                                end
                                if (fres.nonempty) begin
                                    sb_hold_next = fres.sats;
                                end
                                phase_next = PH_STAT_HI;
                            end
                        end
                    end
                    PH_STAT_HI:
                    begin
                        xor_next = xor_reg ^ rx_byte;
                        if (hx[4]) begin
                            hi_nib_next = hx[3:0];
                            phase_next  = PH_STAT_LO;
                        end
                        else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_STAT_LO:
                    begin
                        xor_next = xor_reg ^ rx_byte;
                        if (hx[4]) begin
                            status_next = {hi_nib_reg, hx[3:0]};
                            phase_next  = PH_STAR;
                        end
                        else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_STAR:
                    begin
                        phase_next = (rx_byte == ASC_STAR) ? PH_SUM_HI : PH_IDLE;
                    end
                    PH_SUM_HI:
                    begin
                        if (hx[4]) begin
                            hi_nib_next = hx[3:0];
                            phase_next  = PH_SUM_LO;
                        end
                        else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_SUM_LO:
                    begin
                        if (hx[4] && {hi_nib_reg, hx[3:0]} == xor_reg) begin
                            phase_next = PH_CR;
                        end
                        else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_CR:
                    begin
                        phase_next = (rx_byte == ASC_CR) ? PH_CLOSE : PH_IDLE;
                    end
                    PH_CLOSE:
                    begin
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_IDLE;
            hpos_reg      <= '0;
            hmatch_reg    <= 1'b1;
            comma_reg     <= '0;
            xor_reg       <= '0;
            hi_nib_reg    <= '0;
            status_reg    <= '0;
            week_pend_reg <= '0;
            week_pv_reg   <= 1'b0;
            week_hold_reg <= '0;
            sa_pend_reg   <= '0;
            sa_pv_reg     <= 1'b0;
            sa_hold_reg   <= '0;
            sb_hold_reg   <= '0;
        end
        else begin
            phase_reg     <= phase_next;
            hpos_reg      <= hpos_next;
            hmatch_reg    <= hmatch_next;
            comma_reg     <= comma_next;
            xor_reg       <= xor_next;
            hi_nib_reg    <= hi_nib_next;
            status_reg    <= status_next;
            week_pend_reg <= week_pend_next;
            week_pv_reg   <= week_pv_next;
            week_hold_reg <= week_hold_next;
            sa_pend_reg   <= sa_pend_next;
            sa_pv_reg     <= sa_pv_next;
            sa_hold_reg   <= sa_hold_next;
            sb_hold_reg   <= sb_hold_next;
        end
    end

endmodule

[sv/nsc_checker.sv]
module nsc_checker
    import nsc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic [1:0] nav_expect;

    assign nav_expect = nav_map(m_axis_tdata[7:0]);

    // A stalled result word holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // A fresh result follows an accepted closing byte.
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result word without a closing byte");

    // A dollar sign never closes a sentence.
    a_no_dollar_close: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tdata, 2) != ASC_DOLLAR)
        else $error("result word caused by a dollar sign");

    // The line-feed flag reflects the closing byte.
    a_lf_flag: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> m_axis_tuser == ($past(s_axis_tdata, 2) == ASC_LF))
        else $error("line-feed flag does not match closing byte");

    // Navigation state follows from the status byte.
    a_nav_map: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[9:8] == nav_expect)
        else $error("navigation state does not match status byte");

endmodule

bind nav_sentence_checksum_parser nsc_checker u_nsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
